>>> hw/rtl/swm_pkg.sv
package swm_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int WIN_CFG_W      = 7;
	localparam int MAX_WINDOW_DEF = 64;
	localparam int SEL_GROUP_DEF  = 8;

	localparam logic [WIN_CFG_W-1:0] WIN_RESET = WIN_CFG_W'(3);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [WIN_CFG_W-1:0] win_cfg_t;

	// flags a cell shows to its neighbors
	typedef struct packed {
		logic valid;
		logic g;       // holds a value greater than the incoming sample
		logic rm;      // this cell leaves the window on this step
		logic rm_upto; // removal at this cell or at one closer to the head
	} cell_flags_t;

	// broadcast to every cell
	typedef struct packed {
		logic    step;
		logic    clear;
		logic    del;
		sample_t sample;
	} cell_ctl_t;

endpackage

>>> hw/rtl/swm_sample_if.sv
interface swm_sample_if;
	logic             valid;
	logic             ready;
	swm_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

>>> hw/rtl/swm_median_if.sv
interface swm_median_if;
	logic             valid;
	logic             ready;
	swm_pkg::sample_t median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

>>> hw/rtl/swm_cfg_if.sv
interface swm_cfg_if;
	logic              valid;
	logic              ready;
	swm_pkg::win_cfg_t window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

>>> hw/rtl/sliding_window_median.sv
// running lower median over the last window_size signed 32-bit samples
//
// channels: samples (sink) brings one sample per transaction, medians (source)
// returns one median per transaction, win_cfg (sink) writes window_size and is
// always ready. a write empties the window; write only while the block is idle.
// window_size of zero acts as 1, values above MAX_WINDOW saturate to MAX_WINDOW.
//
// the first window_size - 1 samples after reset or a window write give no
// result; every later sample gives the lower median, element ceil(W/2) in
// ascending order.
//
// throughput: one sample per cycle while medians does not stall; the sorted row
// of cells inserts the new sample and drops the oldest one in the same cycle,
// set by the cell chain. a sample's median passes through the cell update, then
// a two-level registered select tree over the cells, before medians.valid rises.
//
// reset clears all cell valid bits, the fill count and the pipeline valids,
// and sets window_size to 3. when medians stalls, the whole pipeline holds
// and samples.ready drops until the waiting result is taken.
module sliding_window_median #(
	parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
	input logic         clk,
	input logic         arst_n,
	swm_cfg_if.sink     win_cfg,
	swm_sample_if.sink  samples,
	swm_median_if.source medians
);
	import swm_pkg::*;

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	// window register and effective window length
	win_cfg_t      win_q;
	logic [CW-1:0] w_eff;
	logic [CW-1:0] mid;
	logic [AW-1:0] wm1;

	// fill tracking and handshake control
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nx;
	logic          full;
	logic          stall;
	logic          adv;
	logic          accept;
	logic          cfg_wr;
	logic          p0_q;
	logic          v_s1;
	logic          out_valid_q;

	// cell chain
	cell_ctl_t     ctl;
	cell_flags_t   flags [MAX_WINDOW];
	sample_t       vals  [MAX_WINDOW];
	logic [AW-1:0] ages  [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] sel_vec;
	logic [MAX_WINDOW-1:0] valid_vec;
	logic [MAX_WINDOW-1:0] rm_vec;

	// head and tail ties for the chain ends
	cell_flags_t head_f;
	cell_flags_t tail_f;

	always_comb begin
		if (win_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(win_q) > MAX_WINDOW) begin
			w_eff = CW'(MAX_WINDOW);
		end else begin
			w_eff = CW'(win_q);
		end
	end

	assign wm1 = AW'(w_eff - CW'(1));
	assign mid = (w_eff - CW'(1)) >> 1;

	// handshakes
	assign win_cfg.ready = 1'b1;
	assign cfg_wr        = win_cfg.valid;
	assign stall         = out_valid_q && !medians.ready;
	assign adv           = !stall;
	assign samples.ready = adv;
	assign accept        = samples.valid && adv;

	// once full, each sample drops the oldest and the count stays put
	assign full     = (count_q == w_eff);
	assign count_nx = full ? count_q : count_q + CW'(1);

	always_comb begin
		ctl.step   = accept;
		ctl.clear  = cfg_wr;
		ctl.del    = full;
		ctl.sample = samples.sample;
	end

	// the head sees a valid neighbor with nothing greater: an empty slot next
	// to it fills, and nothing shifts in from above
	always_comb begin
		head_f.valid   = 1'b1;
		head_f.g       = 1'b0;
		head_f.rm      = 1'b0;
		head_f.rm_upto = 1'b0;
		tail_f         = '0;
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		cell_flags_t   pf;
		cell_flags_t   nf;
		sample_t       pv;
		sample_t       nv;
		logic [AW-1:0] pa;
		logic [AW-1:0] na;

		if (i == 0) begin : g_head
			assign pf = head_f;
			assign pv = '0;
			assign pa = '0;
		end else begin : g_mid_prev
			assign pf = flags[i-1];
			assign pv = vals[i-1];
			assign pa = ages[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_tail
			assign nf = tail_f;
			assign nv = '0;
			assign na = '0;
		end else begin : g_mid_next
			assign nf = flags[i+1];
			assign nv = vals[i+1];
			assign na = ages[i+1];
		end

		swm_cell #(
			.AW(AW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wm1      (wm1),
			.prev_f   (pf),
			.prev_val (pv),
			.prev_age (pa),
			.next_f   (nf),
			.next_val (nv),
			.next_age (na),
			.own_f    (flags[i]),
			.val      (vals[i]),
			.age      (ages[i])
		);

		// median tap sits at a fixed cell for a given window
		assign sel_vec[i]   = (mid == CW'(i));
		assign valid_vec[i] = flags[i].valid;
		assign rm_vec[i]    = flags[i].rm;
	end

	// window register and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WIN_RESET;
			count_q <= '0;
		end else if (cfg_wr) begin
			win_q   <= win_cfg.window_size;
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nx;
		end
	end

	// result valid pipeline, held as a whole while medians stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q        <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			p0_q        <= accept && (count_nx == w_eff);
			v_s1        <= p0_q;
			out_valid_q <= v_s1;
		end
	end

	swm_sel_tree #(
		.N(MAX_WINDOW),
		.G(SEL_GROUP_DEF)
	) u_sel_tree (
		.clk    (clk),
		.en     (adv),
		.vals   (vals),
		.sel    (sel_vec),
		.result (medians.median)
	);

	assign medians.valid = out_valid_q;

	// fill count never passes the window
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= w_eff)
		else $error("fill count above window");

	// occupied cells always match the fill count
	a_cells_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("cell valid bits disagree with fill count");

	// a full window drops exactly one cell per sample
	a_one_removal: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |-> $onehot(rm_vec))
		else $error("full window without a single leaving cell");

	// nothing leaves while the window is filling
	a_no_early_removal: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (rm_vec == '0))
		else $error("cell removed before window full");

endmodule

>>> hw/rtl/swm_cell.sv
module swm_cell #(
	parameter int AW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swm_pkg::cell_ctl_t   ctl,
	input  logic [AW-1:0]        wm1,
	input  swm_pkg::cell_flags_t prev_f,
	input  swm_pkg::sample_t     prev_val,
	input  logic [AW-1:0]        prev_age,
	input  swm_pkg::cell_flags_t next_f,
	input  swm_pkg::sample_t     next_val,
	input  logic [AW-1:0]        next_age,
	output swm_pkg::cell_flags_t own_f,
	output swm_pkg::sample_t     val,
	output logic [AW-1:0]        age
);
	import swm_pkg::*;

	logic          valid_q;
	sample_t       val_q;
	logic [AW-1:0] age_q;
	logic          take_own;
	logic          take_next;
	logic          take_prev;
	logic          valid_nx;

	always_comb begin
		own_f.valid   = valid_q;
		own_f.g       = valid_q && (val_q > ctl.sample);
		own_f.rm      = ctl.del && valid_q && (age_q == wm1);
		own_f.rm_upto = prev_f.rm_upto | own_f.rm;
	end

	// where this slot's next content comes from
	assign take_own  = valid_q && !own_f.rm && (prev_f.rm_upto == own_f.g);
	assign take_next = next_f.valid && !next_f.rm && own_f.rm_upto && !next_f.g;
	assign take_prev = prev_f.valid && !prev_f.rm_upto && prev_f.g;
	assign valid_nx  = ctl.del ? valid_q : (valid_q | prev_f.valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.step) begin
			valid_q <= valid_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (take_own) begin
				val_q <= val_q;
				age_q <= age_q + AW'(1);
			end else if (take_next) begin
				val_q <= next_val;
				age_q <= next_age + AW'(1);
			end else if (take_prev) begin
				val_q <= prev_val;
				age_q <= prev_age + AW'(1);
			end else begin
				val_q <= ctl.sample;
				age_q <= '0;
			end
		end
	end

	assign val = val_q;
	assign age = age_q;

endmodule

>>> hw/rtl/swm_sel_tree.sv
module swm_sel_tree #(
	parameter int N = 64,
	parameter int G = 8
) (
	input  logic             clk,
	input  logic             en,
	input  swm_pkg::sample_t vals [N],
	input  logic [N-1:0]     sel,
	output swm_pkg::sample_t result
);
	import swm_pkg::*;

	localparam int NG = (N + G - 1) / G;

	sample_t grp_c  [NG];
	sample_t grp_s1 [NG];
	sample_t sum_c;
	sample_t result_q;

	for (genvar gi = 0; gi < NG; gi++) begin : g_grp
		always_comb begin
			grp_c[gi] = '0;
			for (int k = 0; k < G; k++) begin
				if (gi * G + k < N) begin
					if (sel[gi * G + k]) begin
						grp_c[gi] = grp_c[gi] | vals[gi * G + k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				grp_s1[gi] <= grp_c[gi];
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < NG; k++) begin
			sum_c = sum_c | grp_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= sum_c;
		end
	end

	assign result = result_q;

endmodule
